@@ hdl/greedy_box_nms_assert.svh @@
// ----------------------------------------------------------------------------
// Greedy box NMS assertion macros
// Shared property macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_NMS_ASSERT_SVH
`define GREEDY_BOX_NMS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define GBNMS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define GBNMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/gbnms_pkg.sv @@
// ----------------------------------------------------------------------------
// Greedy box NMS package
// Box type, widths and reset values shared by the NMS datapath and control.
// ----------------------------------------------------------------------------
package gbnms_pkg;

   // Default depth of the kept-box table
   localparam int MAX_KEPT_DEFAULT = 64;

   // Threshold register
   localparam int THR_W = 9;
   localparam logic [THR_W-1:0] IOU_THRESHOLD_RESET = 9'd115;

   // Field widths
   localparam int COORD_W = 16;
   localparam int SIZE_W  = 15;
   localparam int INDEX_W = 16;

   // Arithmetic widths
   localparam int AREA_W  = 2 * SIZE_W;       // w*h and intersection
   localparam int UNION_W = AREA_W + 1;       // a + b - i
   localparam int PROD_W  = THR_W + UNION_W;  // threshold * union

   // One box as stored in the kept table
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [SIZE_W-1:0]         w;
      logic [SIZE_W-1:0]         h;
   } box_type;

   // Status of the IoU pipeline toward the controller
   typedef struct packed {
      logic active;  // a comparison is still in flight
      logic hit;     // a kept box suppresses the candidate this cycle
   } iou_stat_type;

endpackage

@@ hdl/gbnms_table.sv @@
// ----------------------------------------------------------------------------
// Greedy box NMS kept table
// Synchronous memory of kept boxes: one write port, one read port with
// registered read data and a matching read-valid flag.
// ----------------------------------------------------------------------------
module gbnms_table #(
   parameter int MAX_KEPT = gbnms_pkg::MAX_KEPT_DEFAULT,
   parameter int IDX_W    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  gbnms_pkg::box_type wr_data,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr,
   output gbnms_pkg::box_type rd_data,
   output logic               rd_valid
);

   gbnms_pkg::box_type mem [MAX_KEPT];
   gbnms_pkg::box_type rd_data_ff;
   logic               rd_valid_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Track which cycles carry fresh read data
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

@@ hdl/gbnms_iou.sv @@
// ----------------------------------------------------------------------------
// Greedy box NMS overlap test
// Five-stage pipeline that tests one kept box per cycle against the
// candidate: intersection * 256 > threshold * union.
// ----------------------------------------------------------------------------
module gbnms_iou (
   input  logic                              clock,
   input  logic                              reset,
   input  gbnms_pkg::box_type                cand,
   input  logic [gbnms_pkg::THR_W-1:0]       threshold,
   input  logic                              kept_valid,
   input  gbnms_pkg::box_type                kept,
   output gbnms_pkg::iou_stat_type           stat
);

   localparam int CW = gbnms_pkg::COORD_W;
   localparam int SW = gbnms_pkg::SIZE_W;
   localparam int AW = gbnms_pkg::AREA_W;
   localparam int UW = gbnms_pkg::UNION_W;
   localparam int PW = gbnms_pkg::PROD_W;

   // Stage valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // Stage 1: overlap edges
   logic signed [CW-1:0] cx, cy, kx, ky;
   logic signed [CW:0]   cx2, cy2, kx2, ky2;
   logic signed [CW-1:0] x1_in, y1_in, x1_ff, y1_ff;
   logic signed [CW:0]   x2_in, y2_in, x2_ff, y2_ff;
   logic [SW-1:0]        kw1_ff, kh1_ff;

   // Stage 2: clipped overlap extents
   logic signed [CW+1:0] ddx, ddy;
   logic [SW-1:0]        dx_in, dy_in, dx_ff, dy_ff;
   logic [SW-1:0]        kw2_ff, kh2_ff;

   // Stage 3: areas
   logic [AW-1:0]        inter3_ff, area_k_ff, area_c_ff;

   // Stage 4: union
   logic [UW-1:0]        union_ff;
   logic [AW-1:0]        inter4_ff;

   // Stage 5: scaled terms
   logic [PW-1:0]        prod_ff;
   logic [AW+7:0]        inter5_ff;

   // Edge arithmetic for stage 1
   always_comb begin
      cx    = cand.x;
      cy    = cand.y;
      kx    = kept.x;
      ky    = kept.y;
      cx2   = (CW+1)'(cx) + $signed({2'b00, cand.w});
      cy2   = (CW+1)'(cy) + $signed({2'b00, cand.h});
      kx2   = (CW+1)'(kx) + $signed({2'b00, kept.w});
      ky2   = (CW+1)'(ky) + $signed({2'b00, kept.h});
      x1_in = (cx > kx) ? cx : kx;
      y1_in = (cy > ky) ? cy : ky;
      x2_in = (cx2 < kx2) ? cx2 : kx2;
      y2_in = (cy2 < ky2) ? cy2 : ky2;
   end

   // Clip to zero where the boxes do not overlap or only touch
   always_comb begin
      ddx   = (CW+2)'(x2_ff) - (CW+2)'(x1_ff);
      ddy   = (CW+2)'(y2_ff) - (CW+2)'(y1_ff);
      dx_in = (ddx > 0) ? ddx[SW-1:0] : '0;
      dy_in = (ddy > 0) ? ddy[SW-1:0] : '0;
   end

   // Advance the datapath
   always_ff @(posedge clock) begin
      x1_ff     <= x1_in;
      y1_ff     <= y1_in;
      x2_ff     <= x2_in;
      y2_ff     <= y2_in;
      kw1_ff    <= kept.w;
      kh1_ff    <= kept.h;

      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      kw2_ff    <= kw1_ff;
      kh2_ff    <= kh1_ff;

      inter3_ff <= AW'(dx_ff) * AW'(dy_ff);
      area_k_ff <= AW'(kw2_ff) * AW'(kh2_ff);
      area_c_ff <= AW'(cand.w) * AW'(cand.h);

      union_ff  <= UW'(area_c_ff) + UW'(area_k_ff) - UW'(inter3_ff);
      inter4_ff <= inter3_ff;

      prod_ff   <= PW'(threshold) * PW'(union_ff);
      inter5_ff <= {inter4_ff, 8'h00};
   end

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= kept_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Report whether anything is still in flight and the compare
   assign stat = {kept_valid | v1_ff | v2_ff | v3_ff | v4_ff | v5_ff,
                  v5_ff && (PW'(inter5_ff) > prod_ff)};

endmodule

@@ hdl/greedy_box_nms.sv @@
// ----------------------------------------------------------------------------
// Greedy box NMS
// Class-agnostic greedy non-maximum suppression over boxes that arrive in
// descending score order, with a kept-box table in synchronous memory.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   request   start & !busy          req_first, req_box_x/y/w/h
//   result    rsp_strobe (1 cycle)   rsp_keep, rsp_box_index, rsp_table_full
//   config    csr_valid & csr_ready  csr_iou_threshold
//
// After acceptance the table read port feeds each of the N kept boxes, one
// per cycle, into a five-stage overlap pipeline (skipped when N is 0); once
// it is empty the result strobe is registered. busy falls in the cycle that
// shows the result, so the next start is taken then. Reset restores state,
// count, position, strobe and threshold; the table is not cleared. The
// result receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module greedy_box_nms #(
   parameter int MAX_KEPT = gbnms_pkg::MAX_KEPT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_first,
   input  logic signed [gbnms_pkg::COORD_W-1:0] req_box_x,
   input  logic signed [gbnms_pkg::COORD_W-1:0] req_box_y,
   input  logic [gbnms_pkg::SIZE_W-1:0]        req_box_w,
   input  logic [gbnms_pkg::SIZE_W-1:0]        req_box_h,
   output logic                                rsp_strobe,
   output logic                                rsp_keep,
   output logic [gbnms_pkg::INDEX_W-1:0]       rsp_box_index,
   output logic                                rsp_table_full,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gbnms_pkg::THR_W-1:0]         csr_iou_threshold
);

   localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W = $clog2(MAX_KEPT + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEPT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type                        state_ff, state_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [IDX_W-1:0]                 scan_ff, scan_in;
   logic [gbnms_pkg::INDEX_W-1:0]    pos_ff, pos_in;
   logic [gbnms_pkg::INDEX_W-1:0]    idx_ff, idx_in;
   logic                             supp_ff, supp_in;
   logic [gbnms_pkg::THR_W-1:0]      thr_ff, thr_in;
   gbnms_pkg::box_type               cand_ff, cand_in;
   logic                             strobe_ff, strobe_in;
   logic                             keep_ff, keep_in;
   logic                             full_ff, full_in;

   logic                             accept;
   logic [CNT_W-1:0]                 count_eff;
   logic                             scan_last;
   logic                             rd_en;
   logic                             wr_en;
   gbnms_pkg::box_type               rd_data;
   logic                             rd_valid;
   gbnms_pkg::iou_stat_type          stat;

   assign accept    = start && (state_ff == ST_IDLE);
   assign count_eff = req_first ? '0 : count_ff;
   assign scan_last = (CNT_W'(scan_ff) + CNT_W'(1)) == count_ff;
   assign rd_en     = (state_ff == ST_SCAN);
   assign wr_en     = (state_ff == ST_FINISH) && !supp_ff && (count_ff != CNT_MAX);

   // Sequence one transaction: scan the table, drain the pipeline, report
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      supp_in   = supp_ff | stat.hit;
      thr_in    = thr_ff;
      cand_in   = cand_ff;
      strobe_in = 1'b0;
      keep_in   = keep_ff;
      full_in   = full_ff;

      // Take a threshold write
      if (csr_valid) begin
         thr_in = csr_iou_threshold;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in    = req_first ? '0 : pos_ff;
               pos_in    = idx_in + 1'b1;
               count_in  = count_eff;
               scan_in   = '0;
               supp_in   = 1'b0;
               cand_in.x = req_box_x;
               cand_in.y = req_box_y;
               cand_in.w = req_box_w;
               cand_in.h = req_box_h;
               state_in  = (count_eff == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.active) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            strobe_in = 1'b1;
            keep_in   = !supp_ff;
            full_in   = !supp_ff && (count_ff == CNT_MAX);
            if (wr_en) begin
               count_in = count_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         pos_ff    <= '0;
         thr_ff    <= gbnms_pkg::IOU_THRESHOLD_RESET;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         thr_ff    <= thr_in;
         strobe_ff <= strobe_in;
      end
      scan_ff <= scan_in;
      idx_ff  <= idx_in;
      supp_ff <= supp_in;
      cand_ff <= cand_in;
      keep_ff <= keep_in;
      full_ff <= full_in;
   end

   gbnms_table #(
      .MAX_KEPT (MAX_KEPT),
      .IDX_W    (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[IDX_W-1:0]),
      .wr_data  (cand_ff),
      .rd_en    (rd_en),
      .rd_addr  (scan_ff),
      .rd_data  (rd_data),
      .rd_valid (rd_valid)
   );

   gbnms_iou u_iou (
      .clock      (clock),
      .reset      (reset),
      .cand       (cand_ff),
      .threshold  (thr_ff),
      .kept_valid (rd_valid),
      .kept       (rd_data),
      .stat       (stat)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_strobe     = strobe_ff;
   assign rsp_keep       = keep_ff;
   assign rsp_box_index  = idx_ff;
   assign rsp_table_full = full_ff;

endmodule

@@ hdl/gbnms_checker.sv @@
// ----------------------------------------------------------------------------
// Greedy box NMS port checker
// Port-level properties of the NMS block, bound onto the top level.
// ----------------------------------------------------------------------------
`include "greedy_box_nms_assert.svh"

module gbnms_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_keep,
   input logic rsp_table_full
);

   // A suppressed box never reports a full table
   `GBNMS_ASSERT_NOW(a_full_only_kept, clock, reset, rsp_strobe && !rsp_keep, !rsp_table_full, "table_full on suppressed box")

   // An accepted transaction makes the block busy
   `GBNMS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised after accept")

   // The result appears exactly when busy drops
   `GBNMS_ASSERT_NOW(a_fall_result, clock, reset, $fell(busy), rsp_strobe, "busy fell without result")

   // A result is shown only while the block is idle
   `GBNMS_ASSERT_NOW(a_result_idle, clock, reset, rsp_strobe, !busy, "result while busy")

   // Results never come in consecutive cycles
   `GBNMS_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe, "result strobe held")

endmodule

bind greedy_box_nms gbnms_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_keep       (rsp_keep),
   .rsp_table_full (rsp_table_full)
);
